FILE: rtl/otsh_pkg.sv
// shared types and constants for the object type/size header encoder
// no dependencies; used by the interfaces and every module of the block
package otsh_pkg;

    localparam int TypeW      = 3;
    localparam int SizeW      = 64;
    localparam int FirstBits  = 4;
    localparam int GroupBits  = 7;
    localparam int RemW       = SizeW - FirstBits;
    localparam int IndexW     = 4;
    localparam int MaxBytes   = 10;

    localparam logic [FirstBits-1:0] FirstSizeMask = 4'hf;
    localparam logic [7:0]           ContFlag      = 8'h80;
    localparam logic [GroupBits-1:0] GroupMask     = 7'h7f;
    localparam logic [TypeW-1:0]     TypeBad       = 3'd0;

    typedef struct packed {
        logic [TypeW-1:0] type_code;
        logic [SizeW-1:0] object_size;
    } t_in_item;

    typedef struct packed {
        logic [7:0]        header_byte;
        logic [IndexW-1:0] byte_index;
        logic              last_byte;
        logic              bad_type;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic advance;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;
    } t_dp_status;

endpackage

FILE: rtl/otsh_if.sv
// valid/ready channel interfaces for the header encoder input and output
// depends on otsh_pkg for the payload types
interface otsh_in_if;
    logic               valid;
    logic               ready;
    otsh_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface otsh_out_if;
    logic                valid;
    logic                ready;
    otsh_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/otsh_ctrl.sv
// controller for the header encoder: handshakes and byte sequencing
// depends on otsh_pkg; drives the datapath through t_dp_cmd
module otsh_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  otsh_pkg::t_dp_status i_status,
    output otsh_pkg::t_dp_cmd    o_cmd
);

    localparam logic StIdle = 1'b0;
    localparam logic StEmit = 1'b1;

    logic r_state;
    logic n_state;
    logic out_fire;
    logic in_fire;

    assign o_out_valid = (r_state == StEmit);
    assign out_fire    = o_out_valid && i_out_ready;
    // the final byte leaving frees the block for the next transaction
    assign o_in_ready  = (r_state == StIdle) || (out_fire && i_status.last);
    assign in_fire     = i_in_valid && o_in_ready;

    assign o_cmd.load    = in_fire;
    assign o_cmd.advance = out_fire && !i_status.last;

    always_comb begin
        n_state = r_state;
        if (in_fire) begin
            n_state = StEmit;
        end else if (out_fire && i_status.last) begin
            n_state = StIdle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
        end else begin
            r_state <= n_state;
        end
    end

    a_load_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_out_valid)
        else $error("no output after accepted transaction");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !(i_out_ready && i_status.last)) |-> !o_cmd.load)
        else $error("load while header still in flight");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("output dropped during stall");

endmodule

FILE: rtl/otsh_dp.sv
// datapath for the header encoder: remaining size, current byte, index
// depends on otsh_pkg; commanded by otsh_ctrl
module otsh_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  otsh_pkg::t_dp_cmd    i_cmd,
    input  otsh_pkg::t_in_item   i_item,
    output otsh_pkg::t_dp_status o_status,
    output otsh_pkg::t_out_item  o_item
);

    logic [otsh_pkg::RemW-1:0]      r_rem;
    logic [otsh_pkg::RemW-1:0]      n_rem;
    logic [otsh_pkg::GroupBits-1:0] r_data;
    logic [otsh_pkg::GroupBits-1:0] n_data;
    logic [otsh_pkg::IndexW-1:0]    r_index;
    logic [otsh_pkg::IndexW-1:0]    n_index;
    logic                           r_last;
    logic                           n_last;
    logic                           r_bad;
    logic                           n_bad;
    logic                           type_bad;
    logic [otsh_pkg::RemW-1:0]      shifted;

    assign type_bad = (i_item.type_code == otsh_pkg::TypeBad);
    assign shifted  = r_rem >> otsh_pkg::GroupBits;

    always_comb begin
        n_rem   = r_rem;
        n_data  = r_data;
        n_index = r_index;
        n_last  = r_last;
        n_bad   = r_bad;
        if (i_cmd.load) begin
            n_index = '0;
            n_bad   = type_bad;
            if (type_bad) begin
                n_rem  = '0;
                n_data = '0;
                n_last = 1'b1;
            end else begin
                n_rem  = i_item.object_size[otsh_pkg::SizeW-1:otsh_pkg::FirstBits];
                n_data = {i_item.type_code,
                          i_item.object_size[otsh_pkg::FirstBits-1:0]
                          & otsh_pkg::FirstSizeMask};
                n_last = (n_rem == '0);
            end
        end else if (i_cmd.advance) begin
            n_data  = r_rem[otsh_pkg::GroupBits-1:0] & otsh_pkg::GroupMask;
            n_rem   = shifted;
            n_index = r_index + 1'b1;
            n_last  = (shifted == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            r_last  <= 1'b1;
            r_bad   <= 1'b0;
        end else begin
            r_index <= n_index;
            r_last  <= n_last;
            r_bad   <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_data <= n_data;
    end

    assign o_status.last      = r_last;
    assign o_item.header_byte = {1'b0, r_data} | (r_last ? 8'h00 : otsh_pkg::ContFlag);
    assign o_item.byte_index  = r_index;
    assign o_item.last_byte   = r_last;
    assign o_item.bad_type    = r_bad;

    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bad |-> (r_last && r_index == '0 && r_data == '0))
        else $error("bad type header not a single zero byte");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_index <= otsh_pkg::IndexW'(otsh_pkg::MaxBytes - 1))
        else $error("byte index past end of header");

    a_advance_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.advance && !i_cmd.load) |=> (r_index == $past(r_index) + 1'b1))
        else $error("byte index did not step");

endmodule

FILE: rtl/object_type_size_header_encoder.sv
// Object type/size header encoder. Each input transaction (type code, 64-bit
// size) becomes a header of 1 to 10 output transactions, one byte each, with
// the index of the byte and a last flag. A type code of zero yields a single
// zero byte with bad_type and last set. Bytes leave one per cycle while the
// sink is ready; the next input is taken in the cycle its predecessor's last
// byte is taken, which makes the byte sequencer the rate limit at one header
// byte per cycle.
// depends on otsh_pkg, otsh_if, otsh_ctrl and otsh_dp
module object_type_size_header_encoder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    otsh_in_if.sink         i_in,
    otsh_out_if.source      o_out
);

    otsh_pkg::t_dp_cmd    cmd;
    otsh_pkg::t_dp_status status;

    otsh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    otsh_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_in.payload),
        .o_status (status),
        .o_item   (o_out.payload)
    );

endmodule
